// ===== rtl/lpcb_pkg.sv =====
// shared constants and types for the line pixel color blend
package lpcb_pkg;
	localparam int BYTE_W = 8;
	localparam int N_CH   = 3;
	localparam int SQ_W   = 2 * BYTE_W;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [SQ_W-1:0]   sq_t;
endpackage

// ===== rtl/lpcb_if.sv =====
// channel interfaces: pixel items in, color items out, mode register writes
interface lpcb_in_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] p_x;
	logic signed [COORD_BITS-1:0] p_y;
	logic [31:0]                  color_a;
	logic [31:0]                  color_b;
	logic [31:0]                  color_p;
	modport source (output valid, a_x, a_y, b_x, b_y, p_x, p_y, color_a, color_b, color_p,
		input ready);
	modport sink (input valid, a_x, a_y, b_x, b_y, p_x, p_y, color_a, color_b, color_p,
		output ready);
endinterface

interface lpcb_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_color;
	modport source (output valid, out_color, input ready);
	modport sink (input valid, out_color, output ready);
endinterface

interface lpcb_cfg_if;
	logic valid;
	logic ready;
	logic blend_mode;
	modport source (output valid, blend_mode, input ready);
	modport sink (input valid, blend_mode, output ready);
endinterface

// ===== rtl/lpcb_dist.sv =====
// first stage: chebyshev distances between the three points
module lpcb_dist #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] p_x,
	input  logic signed [COORD_BITS-1:0] p_y,
	output logic [COORD_BITS:0]          dab_s1,
	output logic [COORD_BITS:0]          dap_s1,
	output logic [COORD_BITS:0]          dpb_s1
);
	localparam int D = COORD_BITS + 1;

	function automatic logic [D-1:0] absdiff(logic signed [COORD_BITS-1:0] u,
		logic signed [COORD_BITS-1:0] w);
		logic signed [D-1:0] d;
		d = $signed({u[COORD_BITS-1], u}) - $signed({w[COORD_BITS-1], w});
		return d[D-1] ? D'(-d) : D'(d);
	endfunction

	function automatic logic [D-1:0] cheb(logic [D-1:0] dx, logic [D-1:0] dy);
		return (dy > dx) ? dy : dx;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			dab_s1 <= cheb(absdiff(a_x, b_x), absdiff(a_y, b_y));
			dap_s1 <= cheb(absdiff(a_x, p_x), absdiff(a_y, p_y));
			dpb_s1 <= cheb(absdiff(p_x, b_x), absdiff(p_y, b_y));
		end
	end
endmodule

// ===== rtl/lpcb_root.sv =====
// pipelined byte root: largest m with m*m*den <= num, one bit per stage
module lpcb_root
	import lpcb_pkg::*;
#(
	parameter int DEN_W = 17,
	parameter int NUM_W = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output byte_t            root
);
	localparam int PW = SQ_W + DEN_W;

	byte_t            m_s   [0:BYTE_W];
	sq_t              sq_s  [0:BYTE_W];
	logic [NUM_W-1:0] num_s [0:BYTE_W];
	logic [DEN_W-1:0] den_s [0:BYTE_W];

	assign m_s[0]   = '0;
	assign sq_s[0]  = '0;
	assign num_s[0] = num;
	assign den_s[0] = den;

	for (genvar k = 0; k < BYTE_W; k++) begin : g_bit
		localparam int B = BYTE_W - 1 - k;
		logic [SQ_W:0] tsq_w;
		logic [PW-1:0] prod;
		logic          take;

		// (m + 2^b)^2 = m^2 + m*2^(b+1) + 2^(2b)
		assign tsq_w = {1'b0, sq_s[k]} + ((SQ_W+1)'(m_s[k]) << (B + 1))
			+ ((SQ_W+1)'(1) << (2 * B));
		assign prod  = PW'(tsq_w[SQ_W-1:0]) * PW'(den_s[k]);
		assign take  = (NUM_W + PW)'(prod) <= (NUM_W + PW)'(num_s[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k+1]   <= take ? (m_s[k] | byte_t'(1 << B)) : m_s[k];
				sq_s[k+1]  <= take ? tsq_w[SQ_W-1:0] : sq_s[k];
				num_s[k+1] <= num_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign root = m_s[BYTE_W];

	// first stage decides only the top bit
	a_first_bit: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> m_s[1][BYTE_W-2:0] == '0)
		else $error("root stage one set a low bit");
endmodule

// ===== rtl/line_pixel_color_blend.sv =====
// top level: chebyshev distance, weighting and rms root pipeline
//
//  channel  | dir | handshake          | payload
//  pixel    | in  | pixel.valid/ready  | a_x a_y b_x b_y p_x p_y color_a color_b color_p
//  result   | out | result.valid/ready | out_color
//  cfg      | in  | cfg.valid/ready    | blend_mode
//
// stages in order: distances, weights and byte squares, weighted sums,
// then one stage per root bit in the three byte root pipelines
// one item per cycle while result is taken; the whole pipe holds when the
// last stage is full and result.ready is low
// reset clears the valid bits and blend_mode; cfg.ready is always high
module line_pixel_color_blend
	import lpcb_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lpcb_in_if.sink    pixel,
	lpcb_out_if.source result,
	lpcb_cfg_if.sink   cfg
);
	localparam int D     = COORD_BITS + 1;
	localparam int NUM_W = D + SQ_W + 1;
	localparam int LAST  = 3 + BYTE_W;

	logic          mode_q;
	logic          adv;
	logic [LAST:1] v_q;

	assign adv         = !v_q[LAST] || result.ready;
	assign pixel.ready = adv;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			v_q    <= '0;
		end else begin
			if (cfg.valid) mode_q <= cfg.blend_mode;
			if (adv) v_q <= {v_q[LAST-1:1], pixel.valid};
		end
	end

	// stage 1
	logic [D-1:0] dab_s1, dap_s1, dpb_s1;
	logic [31:0]  ca_s1, cb_s1, cp_s1;
	logic         mode_s1;

	lpcb_dist #(.COORD_BITS(COORD_BITS)) u_dist (
		.clk(clk), .en(adv),
		.a_x(pixel.a_x), .a_y(pixel.a_y), .b_x(pixel.b_x), .b_y(pixel.b_y),
		.p_x(pixel.p_x), .p_y(pixel.p_y),
		.dab_s1(dab_s1), .dap_s1(dap_s1), .dpb_s1(dpb_s1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ca_s1   <= pixel.color_a;
			cb_s1   <= pixel.color_b;
			cp_s1   <= pixel.color_p;
			mode_s1 <= mode_q;
		end
	end

	// stage 2: bypass choice, weights, byte squares
	logic [D-1:0] dap_sat, dab_s2, wa_s2, wb_s2;
	sq_t          sqa_s2 [N_CH];
	sq_t          sqb_s2 [N_CH];
	logic [LAST:2] byp_q;
	logic [31:0]  bcol_q [2:LAST];
	logic         byp_n;
	logic [31:0]  bcol_n;

	assign dap_sat = (dap_s1 > dab_s1) ? dab_s1 : dap_s1;

	always_comb begin
		byp_n  = 1'b1;
		bcol_n = cb_s1;
		if (ca_s1 == cb_s1) begin
			bcol_n = cp_s1;
		end else if (!mode_s1) begin
			bcol_n = (dpb_s1 > dap_s1) ? ca_s1 : cb_s1;
		end else if (dab_s1 != '0) begin
			byp_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dab_s2 <= dab_s1;
			wa_s2  <= dab_s1 - dap_sat;
			wb_s2  <= dap_sat;
			for (int c = 0; c < N_CH; c++) begin
				sqa_s2[c] <= SQ_W'(ca_s1[c*BYTE_W +: BYTE_W]) * SQ_W'(ca_s1[c*BYTE_W +: BYTE_W]);
				sqb_s2[c] <= SQ_W'(cb_s1[c*BYTE_W +: BYTE_W]) * SQ_W'(cb_s1[c*BYTE_W +: BYTE_W]);
			end
			byp_q[2]  <= byp_n;
			bcol_q[2] <= bcol_n;
			for (int k = 3; k <= LAST; k++) begin
				byp_q[k]  <= byp_q[k-1];
				bcol_q[k] <= bcol_q[k-1];
			end
		end
	end

	// stage 3: weighted sums of squares
	logic [NUM_W-1:0] num_s3 [N_CH];
	logic [D-1:0]     dab_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dab_s3 <= dab_s2;
			for (int c = 0; c < N_CH; c++) begin
				num_s3[c] <= NUM_W'(wa_s2) * NUM_W'(sqa_s2[c])
					+ NUM_W'(wb_s2) * NUM_W'(sqb_s2[c]);
			end
		end
	end

	// stages 4 to 11: byte roots
	byte_t rgb [N_CH];

	for (genvar c = 0; c < N_CH; c++) begin : g_ch
		lpcb_root #(.DEN_W(D), .NUM_W(NUM_W)) u_root (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.num(num_s3[c]), .den(dab_s3), .root(rgb[c])
		);
	end

	assign result.valid     = v_q[LAST];
	assign result.out_color = byp_q[LAST] ? bcol_q[LAST]
		: {BYTE_W'(0), rgb[2], rgb[1], rgb[0]};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_q))
		else $error("valid bits moved during a stall");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_q[LAST-1] |=> v_q[LAST])
		else $error("item lost before the last stage");

	a_grad: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[2] && !byp_q[2] |-> dab_s2 != '0)
		else $error("gradient item with zero length segment");
endmodule
